FILE: design/idp_pkg.sv
`default_nettype none

package idp_pkg;

	// Width of one vector element as it travels on the input bus.
	localparam int ELEM_W = 32;
	// Width of the low slice used by the narrow unsigned mode.
	localparam int NARROW_W = 8;
	// Width of a product, of the accumulator and of a result.
	localparam int SUM_W = 64;
	// Width of the narrow-mode result before zero extension.
	localparam int NARROW_SUM_W = 32;

	typedef enum logic {
		MODE_U8  = 1'b0,
		MODE_S32 = 1'b1
	} elem_mode_t;

	// Control that travels alongside the data through each pipeline stage.
	typedef struct packed {
		logic       last;
		elem_mode_t mode;
	} ctl_t;

endpackage

`default_nettype wire

FILE: design/idp_lane.sv
`default_nettype none

module idp_lane (
	input  wire logic                            clk,
	input  wire logic                            load,
	input  wire idp_pkg::elem_mode_t             mode,
	input  wire logic                            use_lane,
	input  wire logic [idp_pkg::ELEM_W-1:0]      left,
	input  wire logic [idp_pkg::ELEM_W-1:0]      right,
	output logic      [idp_pkg::SUM_W-1:0]       prod_s1
);

	// Both modes share one signed multiplier one bit wider than an element,
	// so the narrow mode can present its operands zero-extended.
	logic signed [idp_pkg::ELEM_W:0]     left_x;
	logic signed [idp_pkg::ELEM_W:0]     right_x;
	logic signed [2*idp_pkg::ELEM_W+1:0] product;

	always_comb begin
		if (mode == idp_pkg::MODE_S32) begin
			left_x  = {left[idp_pkg::ELEM_W-1], left};
			right_x = {right[idp_pkg::ELEM_W-1], right};
		end else begin
			left_x  = {{(idp_pkg::ELEM_W+1-idp_pkg::NARROW_W){1'b0}},
				left[idp_pkg::NARROW_W-1:0]};
			right_x = {{(idp_pkg::ELEM_W+1-idp_pkg::NARROW_W){1'b0}},
				right[idp_pkg::NARROW_W-1:0]};
		end
		product = left_x * right_x;
	end

	// Lanes beyond the valid count contribute nothing.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= use_lane ? product[idp_pkg::SUM_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

FILE: design/idp_merge.sv
`default_nettype none

module idp_merge #(
	parameter int LANES = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire idp_pkg::ctl_t              in_ctl,
	input  wire logic [idp_pkg::SUM_W-1:0]  prod [LANES],
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [idp_pkg::SUM_W-1:0]  out_sum
);

	// Tree depth and the number of leaves after padding to a power of two.
	localparam int T = $clog2(LANES);
	localparam int P = 1 << T;

	// Stage 0 is the lane product register; stage j holds tree depth T-j.
	logic          vld     [T+1];
	idp_pkg::ctl_t ctl     [T+1];
	logic          rdy_out [T+1];

	// Heap-ordered nodes: node 1 is the root, leaves sit at P..2P-1.
	logic [idp_pkg::SUM_W-1:0] node_c [1:2*P-1];

	logic                      sink_go;
	logic                      sink_ready;
	logic [idp_pkg::SUM_W-1:0] acc_q;
	logic [idp_pkg::SUM_W-1:0] acc_sum;
	logic                      out_vld_q;
	logic [idp_pkg::SUM_W-1:0] out_sum_q;

	assign vld[0] = in_valid;
	assign ctl[0] = in_ctl;
	assign in_ready = rdy_out[0];

	// Non-last items may always drain into the accumulator; a last item
	// needs the output register free or being emptied.
	assign sink_ready = !ctl[T].last || !out_vld_q || out_ready;
	assign rdy_out[T] = sink_ready;

	for (genvar j = 0; j < T; j++) begin : g_rdy
		assign rdy_out[j] = !vld[j+1] || rdy_out[j+1];
	end

	for (genvar j = 1; j <= T; j++) begin : g_stage
		logic          vld_q;
		idp_pkg::ctl_t ctl_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
				ctl_q <= '0;
			end else if (rdy_out[j-1]) begin
				vld_q <= vld[j-1];
				ctl_q <= ctl[j-1];
			end
		end

		assign vld[j] = vld_q;
		assign ctl[j] = ctl_q;
	end

	for (genvar k = P; k < 2*P; k++) begin : g_leaf
		if (k - P < LANES) begin : g_used
			assign node_c[k] = prod[k-P];
		end else begin : g_pad
			assign node_c[k] = '0;
		end
	end

	for (genvar k = 1; k < P; k++) begin : g_node
		localparam int D = $clog2(k + 1) - 1;
		localparam int J = T - D;
		logic [idp_pkg::SUM_W-1:0] sum_q;

		always_ff @(posedge clk) begin
			if (rdy_out[J-1] && vld[J-1]) begin
				sum_q <= node_c[2*k] + node_c[2*k+1];
			end
		end

		assign node_c[k] = sum_q;
	end

	assign sink_go = vld[T] && sink_ready;
	assign acc_sum = acc_q + node_c[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (sink_go && ctl[T].last) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (sink_go) begin
				if (ctl[T].last) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sink_go && ctl[T].last) begin
			if (ctl[T].mode == idp_pkg::MODE_S32) begin
				out_sum_q <= acc_sum;
			end else begin
				out_sum_q <= {{(idp_pkg::SUM_W-idp_pkg::NARROW_SUM_W){1'b0}},
					acc_sum[idp_pkg::NARROW_SUM_W-1:0]};
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_sum   = out_sum_q;

endmodule

`default_nettype wire

FILE: design/integer_dot_product_core.sv
`default_nettype none

// Streaming integer dot product.
// Each input transfer on the s_axis channel carries LANES pairs of vector
// elements and a count of how many of the lowest lanes hold valid pairs;
// s_axis_tlast marks the final transfer of a vector. The products of all
// valid pairs are added into a running 64-bit accumulator, and on the last
// transfer the dot product leaves on the m_axis channel as one transfer,
// after which the accumulator starts again from zero. An empty vector gives
// zero; a count above LANES uses every lane.
// element_mode is written through cfg_we/cfg_data while the block is idle:
// 0 takes the low 8 bits of each element unsigned and returns the sum
// modulo 2^32, zero-extended; 1 takes full signed 32-bit elements and
// returns the sum modulo 2^64.
// Throughput is one transfer per clock while no finished vector waits for
// the output register, set by one multiplier per lane and a pipelined adder
// tree. The edge that accepts a transfer loads the lane products; the sum
// then passes one register per adder-tree level and finally the accumulator
// and output register. Reset clears pipeline, accumulator, mode.
// When the receiver stalls, transfers that do not end a vector keep being
// taken into the accumulator; only a finished vector waits for the output
// register, and back-pressure then travels up the pipeline to s_axis_tready.
module integer_dot_product_core #(
	parameter int LANES = 4,
	localparam int CNT_W = $clog2(LANES + 1),
	localparam int DATA_W = ((2*LANES*idp_pkg::ELEM_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_we,
	input  wire logic                       cfg_data,      // element_mode

	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// left_0 .. left_{LANES-1}, right_0 .. right_{LANES-1}, valid_pairs,
	// then zero fill up to a whole byte
	input  wire logic [DATA_W-1:0]          s_axis_tdata,
	input  wire logic                       s_axis_tlast,  // is_last

	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic      [idp_pkg::SUM_W-1:0]  m_axis_tdata   // dot_sum
);

	localparam int CNT_LSB = 2 * LANES * idp_pkg::ELEM_W;

	idp_pkg::elem_mode_t       mode_q;
	logic                      vld_s1;
	idp_pkg::ctl_t             ctl_s1;
	logic                      merge_ready;
	logic                      in_go;
	logic [CNT_W-1:0]          valid_pairs;
	logic [idp_pkg::SUM_W-1:0] prod_s1 [LANES];

	// The mode register; only its one bit is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= idp_pkg::MODE_U8;
		end else if (cfg_we) begin
			mode_q <= idp_pkg::elem_mode_t'(cfg_data);
		end
	end

	// The product stage takes a new transfer whenever it is empty or its
	// current contents move on into the adder tree in the same cycle.
	assign s_axis_tready = !vld_s1 || merge_ready;
	assign in_go         = s_axis_tvalid && s_axis_tready;
	assign valid_pairs   = s_axis_tdata[CNT_LSB +: CNT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (s_axis_tready) begin
			vld_s1      <= s_axis_tvalid;
			ctl_s1.last <= s_axis_tlast;
			ctl_s1.mode <= mode_q;
		end
	end

	// One multiplier per lane. A lane is used when its index is below the
	// count, so a count above LANES simply enables every lane.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		idp_lane u_lane (
			.clk      (clk),
			.load     (in_go),
			.mode     (mode_q),
			.use_lane (CNT_W'(i) < valid_pairs),
			.left     (s_axis_tdata[i*idp_pkg::ELEM_W +: idp_pkg::ELEM_W]),
			.right    (s_axis_tdata[(LANES+i)*idp_pkg::ELEM_W +: idp_pkg::ELEM_W]),
			.prod_s1  (prod_s1[i])
		);
	end

	// Adder tree over the lane products, accumulator and output register.
	idp_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (merge_ready),
		.in_ctl    (ctl_s1),
		.prod      (prod_s1),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sum   (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/dot_product_checker.sv
`timescale 1ns / 100ps

// Observes the input, output and configuration ports of the dot-product core.
// It keeps its own accumulator and element mode, and compares every result
// that leaves the block with the oldest predicted dot product.
module dot_product_checker
	import idp_pkg::*;
#(
	parameter int LANES = 4,
	parameter int CNT_W = $clog2(LANES + 1),
	parameter int DATA_W = ((2*LANES*ELEM_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_data,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic              s_tlast,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [SUM_W-1:0]  m_tdata,
	output int                     mismatches = 0,
	output int                     results_pending = 0
);

	logic [SUM_W-1:0] dot_acc;
	logic [SUM_W-1:0] due_sum;
	elem_mode_t       cur_mode;
	logic [SUM_W-1:0] expected_sums[$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Product of one pair of elements in the given mode, reduced to 64 bits.
	function automatic logic [SUM_W-1:0] pair_term(input logic [ELEM_W-1:0] a,
			input logic [ELEM_W-1:0] b, input elem_mode_t m);
		longint sa;
		longint sb;
		if (m == MODE_U8) begin
			return SUM_W'(a[NARROW_W-1:0]) * SUM_W'(b[NARROW_W-1:0]);
		end
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		return SUM_W'(sa * sb);
	endfunction

	// Sum of the products of the valid lanes of one transfer.
	function automatic logic [SUM_W-1:0] transfer_sum(input logic [DATA_W-1:0] d,
			input elem_mode_t m);
		logic [SUM_W-1:0] s;
		int               pairs;
		s = '0;
		pairs = int'(d[2*LANES*ELEM_W +: CNT_W]);
		if (pairs > LANES) begin
			pairs = LANES;
		end
		for (int i = 0; i < pairs; i++) begin
			s += pair_term(d[i*ELEM_W +: ELEM_W], d[(LANES+i)*ELEM_W +: ELEM_W], m);
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_acc = '0;
			cur_mode = MODE_U8;
			expected_sums.delete();
			results_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("dot product %h arrived with none due", m_tdata));
				end else begin
					due_sum = expected_sums.pop_front();
					if (m_tdata !== due_sum) begin
						report_mismatch($sformatf("dot_sum %h, expected %h", m_tdata, due_sum));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				dot_acc += transfer_sum(s_tdata, cur_mode);
				if (s_tlast) begin
					// Narrow mode keeps only the low 32 bits of the accumulator.
					if (cur_mode == MODE_U8) begin
						expected_sums.push_back(SUM_W'(dot_acc[NARROW_SUM_W-1:0]));
					end else begin
						expected_sums.push_back(dot_acc);
					end
					dot_acc = '0;
				end
			end
			if (cfg_we) begin
				cur_mode = elem_mode_t'(cfg_data);
			end
			results_pending = expected_sums.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Top level of the dot-product testbench. This module only produces the
// stimulus and gives the verdict; the checker beside the block predicts every
// dot product and compares it with what leaves the output channel.
module testbench;
	import idp_pkg::*;

	localparam int LANES = 4;
	localparam int CNT_W = $clog2(LANES + 1);
	localparam int DATA_W = ((2*LANES*ELEM_W + CNT_W + 7) / 8) * 8;
	// Cycles from the last input transfer of a vector to its result.
	localparam int LATENCY = $clog2(LANES) + 1;
	// Longest stretch without any transfer before the run is declared hung.
	localparam int QUIET_LIMIT = 3000;
	// Length of the deliberate hold-off on the output channel.
	localparam int HOLD_CYCLES = 300;

	// One input transfer, packed so that the left elements sit lowest.
	typedef struct packed {
		logic                         last;
		logic [CNT_W-1:0]             pairs;
		logic [LANES-1:0][ELEM_W-1:0] right;
		logic [LANES-1:0][ELEM_W-1:0] left;
	} vec_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_data = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// left_0 .. left_3, right_0 .. right_3, valid_pairs, zero fill
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;    // is_last
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [SUM_W-1:0]  m_axis_tdata;           // dot_sum

	int mismatches;
	int results_pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	integer_dot_product_core #(.LANES(LANES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	dot_product_checker #(.LANES(LANES)) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_axis_tvalid),
		.s_tready        (s_axis_tready),
		.s_tdata         (s_axis_tdata),
		.s_tlast         (s_axis_tlast),
		.m_tvalid        (m_axis_tvalid),
		.m_tready        (m_axis_tready),
		.m_tdata         (m_axis_tdata),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	// Receiver. While a hold-off is running it refuses every transfer, so
	// that finished vectors back up through the pipeline to s_axis_tready;
	// otherwise it stalls at random with the current idle percentage.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Element values with a strong bias towards the corners of both modes.
	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h0000_00FF;
			5: return 32'($urandom_range(255));
			default: return $urandom();
		endcase
	endfunction

	function automatic vec_item_t uniform_item(input logic [ELEM_W-1:0] a,
			input logic [ELEM_W-1:0] b, input int pairs, input logic last);
		vec_item_t it;
		for (int i = 0; i < LANES; i++) begin
			it.left[i] = a;
			it.right[i] = b;
		end
		it.pairs = CNT_W'(pairs);
		it.last = last;
		return it;
	endfunction

	// Most transfers use every lane; the rest cover the full count field,
	// including the values above LANES that saturate.
	function automatic vec_item_t random_item(input logic last);
		vec_item_t it;
		for (int i = 0; i < LANES; i++) begin
			it.left[i] = rand_elem();
			it.right[i] = rand_elem();
		end
		it.pairs = ($urandom_range(9) < 7) ? CNT_W'(LANES) : CNT_W'($urandom_range(7));
		it.last = last;
		return it;
	endfunction

	// Offers one transfer and returns at the edge where it is taken. tvalid
	// stays high on return, so back-to-back transfers leave no gap.
	task automatic send_item(input vec_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DATA_W'({it.pairs, it.right, it.left});
		s_axis_tlast <= it.last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// The sender pauses until every due dot product has arrived, then lets
	// the pipeline run dry in case a vector is still half accumulated.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_mode(input elem_mode_t m);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Vectors of one to six transfers with random contents. A block may stop
	// in the middle of a vector, so the next block finishes it, possibly in
	// another mode.
	task automatic send_random_vectors(input int n);
		vec_item_t it;
		int        sent;
		int        len;
		sent = 0;
		while (sent < n) begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len && sent < n; k++) begin
				it = random_item(k == len - 1);
				// Now and then an empty vector: count zero with tlast.
				if (len == 1 && $urandom_range(7) == 0) begin
					it.pairs = '0;
				end
				send_item(it);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(MODE_U8);

		// Narrow mode: largest bytes, high bits that must be ignored, an
		// empty vector, a saturating count and a vector over several transfers
		// whose last transfer carries no pairs.
		send_item(uniform_item(32'h0000_00FF, 32'h0000_00FF, LANES, 1'b1));
		send_item(uniform_item(32'hFFFF_FF80, 32'h1234_5603, LANES, 1'b1));
		send_item(uniform_item(32'h0000_0000, 32'h0000_0000, 0, 1'b1));
		send_item(uniform_item(32'h0000_0011, 32'h0000_0022, 7, 1'b1));
		send_item(uniform_item(32'h0000_00FF, 32'h0000_00FF, 2, 1'b0));
		send_item(uniform_item(32'h0000_0003, 32'h0000_0005, 3, 1'b0));
		send_item(uniform_item(32'h0000_00AA, 32'h0000_0055, 0, 1'b1));
		wait_for_results();
		write_mode(MODE_S32);

		// Wide mode: the signed extremes, including four products of the most
		// negative value that wrap the 64-bit sum round to zero.
		send_item(uniform_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, LANES, 1'b1));
		send_item(uniform_item(32'h8000_0000, 32'h8000_0000, LANES, 1'b1));
		send_item(uniform_item(32'h8000_0000, 32'h7FFF_FFFF, LANES, 1'b1));
		send_item(uniform_item(32'hFFFF_FFFF, 32'h8000_0000, 5, 1'b1));
		send_item(uniform_item(32'h0000_0000, 32'h0000_0000, 0, 1'b1));
		send_item(random_item(1'b0));
		send_item(uniform_item(32'hFFFF_FFFF, 32'h0000_0001, 6, 1'b1));

		// Mode changes inside a vector: a large signed sum finished in narrow
		// mode keeps only its low word, and the reverse.
		send_item(uniform_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, LANES, 1'b0));
		wait_for_results();
		write_mode(MODE_U8);
		send_item(uniform_item(32'h0000_00FF, 32'h0000_00FF, 1, 1'b1));
		send_item(uniform_item(32'h0000_00FF, 32'h0000_00FE, LANES, 1'b0));
		wait_for_results();
		write_mode(MODE_S32);
		send_item(uniform_item(32'h8000_0000, 32'hFFFF_FFFF, LANES, 1'b1));

		// Long hold-off on the output while the sender keeps offering
		// transfers: the block has to fill up and stall its input.
		wait_for_results();
		rx_hold_left <= HOLD_CYCLES;
		send_random_vectors(40);

		// Random part in three idling regimes, with the mode rewritten on an
		// idle block before every group of transfers.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 14;
					rx_idle_pct = 78;
				end
				1: begin
					tx_idle_pct = 78;
					rx_idle_pct = 14;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int grp = 0; grp < 3; grp++) begin
				wait_for_results();
				write_mode(elem_mode_t'($urandom_range(1)));
				send_random_vectors(88);
			end
		end

		wait_for_results();
		if (results_pending != 0) begin
			$display("%0d dot products never arrived", results_pending);
		end
		if (mismatches == 0 && results_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
